FILE: src/timed_azimuth_rotor_controller_unit_macros.svh
// Assertion macros shared by the rotor controller RTL.
`ifndef TIMED_AZIMUTH_ROTOR_CONTROLLER_UNIT_MACROS_SVH
`define TIMED_AZIMUTH_ROTOR_CONTROLLER_UNIT_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define TARC_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rotor controller check failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define TARC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rotor controller check failed");

`endif

FILE: src/tarc_pkg.sv
// Types, constants and helper functions of the timed azimuth rotor controller.
`default_nettype none

package tarc_pkg;

   localparam logic [1:0] MODE_IDLE    = 2'd0;
   localparam logic [1:0] MODE_TURN    = 2'd1;
   localparam logic [1:0] MODE_JOG_CW  = 2'd2;
   localparam logic [1:0] MODE_JOG_CCW = 2'd3;

   localparam logic [1:0] REG_MS_PER_DEGREE = 2'd0;
   localparam logic [1:0] REG_DEADBAND      = 2'd1;

   localparam logic [7:0] START_CHAR = 8'd65;
   localparam logic [7:0] SPACE_CHAR = 8'd32;
   localparam logic [7:0] DIGIT_ZERO = 8'd48;
   localparam logic [7:0] DIGIT_NINE = 8'd57;

   localparam logic [3:0] FIELD_FIRST = 4'd2;
   localparam logic [3:0] FIELD_LAST  = 4'd4;

   localparam logic [9:0] MAX_TARGET = 10'd359;
   localparam logic [8:0] MAX_POS    = 9'd360;

   localparam logic [7:0] RESET_MS_PER_DEGREE = 8'd180;
   localparam logic [8:0] RESET_DEADBAND      = 9'd5;

   typedef struct packed {
      logic       pad;
      logic [1:0] mode;
      logic [8:0] azimuth;
      logic       ccw_lamp;
      logic       cw_lamp;
      logic       dir_relay;
      logic       run_relay;
   } rsp_word_type;

   typedef struct packed {
      logic       ccw_button;
      logic       cw_button;
      logic [7:0] rx_byte;
   } req_word_type;

   // Live azimuth: position moved by the degrees counted so far in a jog.
   function automatic logic [8:0] jog_estimate(logic [1:0] mode, logic [8:0] pos,
                                               logic [8:0] jog);
      logic [9:0] sum;
      sum = {1'b0, pos} + {1'b0, jog};
      unique case (mode)
         MODE_JOG_CW:  jog_estimate = (sum > {1'b0, MAX_POS}) ? MAX_POS : sum[8:0];
         MODE_JOG_CCW: jog_estimate = (pos >= jog) ? (pos - jog) : 9'd0;
         default:      jog_estimate = pos;
      endcase
   endfunction

endpackage

`default_nettype wire

FILE: src/timed_azimuth_rotor_controller_unit.sv
// A word's result is registered in out_ff, or in skid_ff while out_ff waits, before it shows on rsp_tvalid.
// Throughput: one word per cycle while req_tready is high; all state updates sit in one logic level set
// between the accepted word and the result register.
// A two-entry result buffer keeps req_tready high while one result waits.
// Synchronous active-high reset returns all state but the buffer's data words, and both registers, to defaults.
`default_nettype none
`include "timed_azimuth_rotor_controller_unit_macros.svh"

module timed_azimuth_rotor_controller_unit #(
   parameter int FRAME_BYTES = 12
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // rx_byte[7:0], cw_button[8], ccw_button[9]
   input  wire logic        req_tuser,   // kind[0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // run_relay, dir_relay, cw_lamp, ccw_lamp,
                                         // azimuth[12:4], mode[14:13]
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [8:0]  csr_data
);

   tarc_pkg::req_word_type req_word;
   tarc_pkg::rsp_word_type result;
   tarc_pkg::rsp_word_type out_ff, skid_ff;
   logic out_valid_ff, skid_valid_ff;

   logic [7:0] ms_per_degree_ff;
   logic [8:0] deadband_ff;

   logic [8:0] position_ff, position_in;
   logic [3:0] frame_index_ff, frame_index_in;
   logic [9:0] target_accum_ff, target_accum_in;
   logic       digits_closed_ff, digits_closed_in;
   logic       digit_seen_ff, digit_seen_in;
   logic [8:0] pending_target_ff, pending_target_in;
   logic [8:0] degrees_left_ff, degrees_left_in;
   logic [7:0] ms_in_degree_ff, ms_in_degree_in;
   logic [1:0] run_mode_ff, run_mode_in;
   logic [8:0] jog_degrees_ff, jog_degrees_in;
   logic       direction_bit_ff, direction_bit_in;
   logic [1:0] lamp_bits_ff, lamp_bits_in;

   logic       req_accept, rsp_pop;
   logic       degree_done, jog_active, held, is_digit;
   logic [7:0] ms_step;
   logic [8:0] est_cur, target, absdiff, degrees_dec;
   logic [13:0] accum_times_ten;

   assign req_word   = req_tdata[9:0];
   assign req_tready = !skid_valid_ff;
   assign req_accept = req_tvalid && req_tready;
   assign rsp_pop    = out_valid_ff && rsp_tready;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_ff;
   assign csr_ready  = 1'b1;

   assign degree_done = ({1'b0, ms_in_degree_ff} + 9'd1) >= {1'b0, ms_per_degree_ff};
   assign ms_step     = degree_done ? 8'd0 : ms_in_degree_ff + 8'd1;
   assign jog_active  = (run_mode_ff == tarc_pkg::MODE_JOG_CW) ||
                        (run_mode_ff == tarc_pkg::MODE_JOG_CCW);
   assign held        = (run_mode_ff == tarc_pkg::MODE_JOG_CW) ? req_word.cw_button
                                                               : req_word.ccw_button;
   assign est_cur     = tarc_pkg::jog_estimate(run_mode_ff, position_ff, jog_degrees_ff);
   assign is_digit    = (req_word.rx_byte >= tarc_pkg::DIGIT_ZERO) &&
                        (req_word.rx_byte <= tarc_pkg::DIGIT_NINE);
   assign accum_times_ten = {1'b0, target_accum_ff, 3'b000} + {3'b000, target_accum_ff, 1'b0};
   assign degrees_dec = (degrees_left_ff == 9'd0) ? 9'd0 : degrees_left_ff - 9'd1;

   always_comb begin
      position_in       = position_ff;
      frame_index_in    = frame_index_ff;
      target_accum_in   = target_accum_ff;
      digits_closed_in  = digits_closed_ff;
      digit_seen_in     = digit_seen_ff;
      pending_target_in = pending_target_ff;
      degrees_left_in   = degrees_left_ff;
      ms_in_degree_in   = ms_in_degree_ff;
      run_mode_in       = run_mode_ff;
      jog_degrees_in    = jog_degrees_ff;
      direction_bit_in  = direction_bit_ff;
      lamp_bits_in      = lamp_bits_ff;
      target            = 9'd0;
      absdiff           = 9'd0;
      if (req_accept && !req_tuser && run_mode_ff == tarc_pkg::MODE_IDLE) begin
         if (frame_index_ff == 4'd0) begin
            if (req_word.rx_byte == tarc_pkg::START_CHAR) begin
               frame_index_in   = 4'd1;
               target_accum_in  = 10'd0;
               digits_closed_in = 1'b0;
               digit_seen_in    = 1'b0;
            end
         end else begin
            if (frame_index_ff >= tarc_pkg::FIELD_FIRST &&
                frame_index_ff <= tarc_pkg::FIELD_LAST && !digits_closed_ff) begin
               if (is_digit) begin
                  target_accum_in = accum_times_ten[9:0] +
                                    {2'b00, req_word.rx_byte - tarc_pkg::DIGIT_ZERO};
                  digit_seen_in   = 1'b1;
               end else if (!(req_word.rx_byte == tarc_pkg::SPACE_CHAR && !digit_seen_ff)) begin
                  digits_closed_in = 1'b1;
               end
            end
            if (frame_index_ff >= 4'(FRAME_BYTES)) begin
               frame_index_in    = 4'd0;
               target            = (target_accum_in > tarc_pkg::MAX_TARGET) ?
                                   tarc_pkg::MAX_TARGET[8:0] : target_accum_in[8:0];
               pending_target_in = target;
               if (target < position_ff) begin
                  lamp_bits_in     = 2'b10;
                  direction_bit_in = 1'b0;
                  absdiff          = position_ff - target;
               end else if (target > position_ff) begin
                  lamp_bits_in     = 2'b01;
                  direction_bit_in = 1'b1;
                  absdiff          = target - position_ff;
               end else begin
                  lamp_bits_in = 2'b00;
               end
               if (absdiff > deadband_ff) begin
                  run_mode_in     = tarc_pkg::MODE_TURN;
                  degrees_left_in = absdiff;
                  ms_in_degree_in = 8'd0;
               end
            end else begin
               frame_index_in = frame_index_ff + 4'd1;
            end
         end
      end else if (req_accept && req_tuser) begin
         if (run_mode_ff == tarc_pkg::MODE_TURN) begin
            ms_in_degree_in = ms_step;
            if (degree_done) begin
               degrees_left_in = degrees_dec;
               if (degrees_dec == 9'd0) begin
                  position_in = pending_target_ff;
                  run_mode_in = tarc_pkg::MODE_IDLE;
               end
            end
         end else if (jog_active && held) begin
            ms_in_degree_in = ms_step;
            if (degree_done && jog_degrees_ff < tarc_pkg::MAX_POS) begin
               jog_degrees_in = jog_degrees_ff + 9'd1;
            end
         end else begin
            if (jog_active) begin
               position_in = est_cur;
               run_mode_in = tarc_pkg::MODE_IDLE;
            end
            if (req_word.ccw_button) begin
               run_mode_in      = tarc_pkg::MODE_JOG_CCW;
               lamp_bits_in     = lamp_bits_ff | 2'b10;
               direction_bit_in = 1'b0;
               ms_in_degree_in  = 8'd0;
               jog_degrees_in   = 9'd0;
            end else if (req_word.cw_button) begin
               run_mode_in      = tarc_pkg::MODE_JOG_CW;
               lamp_bits_in     = lamp_bits_ff | 2'b01;
               direction_bit_in = 1'b1;
               ms_in_degree_in  = 8'd0;
               jog_degrees_in   = 9'd0;
            end
         end
      end
   end

   always_comb begin
      result.pad       = 1'b0;
      result.mode      = run_mode_in;
      result.azimuth   = tarc_pkg::jog_estimate(run_mode_in, position_in, jog_degrees_in);
      result.ccw_lamp  = lamp_bits_in[1];
      result.cw_lamp   = lamp_bits_in[0];
      result.dir_relay = direction_bit_in;
      result.run_relay = (run_mode_in != tarc_pkg::MODE_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ms_per_degree_ff  <= tarc_pkg::RESET_MS_PER_DEGREE;
         deadband_ff       <= tarc_pkg::RESET_DEADBAND;
         position_ff       <= 9'd0;
         frame_index_ff    <= 4'd0;
         target_accum_ff   <= 10'd0;
         digits_closed_ff  <= 1'b0;
         digit_seen_ff     <= 1'b0;
         pending_target_ff <= 9'd0;
         degrees_left_ff   <= 9'd0;
         ms_in_degree_ff   <= 8'd0;
         run_mode_ff       <= tarc_pkg::MODE_IDLE;
         jog_degrees_ff    <= 9'd0;
         direction_bit_ff  <= 1'b0;
         lamp_bits_ff      <= 2'b00;
      end else begin
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               tarc_pkg::REG_MS_PER_DEGREE: ms_per_degree_ff <= csr_data[7:0];
               tarc_pkg::REG_DEADBAND:      deadband_ff      <= csr_data;
               default: ;
            endcase
         end
         position_ff       <= position_in;
         frame_index_ff    <= frame_index_in;
         target_accum_ff   <= target_accum_in;
         digits_closed_ff  <= digits_closed_in;
         digit_seen_ff     <= digit_seen_in;
         pending_target_ff <= pending_target_in;
         degrees_left_ff   <= degrees_left_in;
         ms_in_degree_ff   <= ms_in_degree_in;
         run_mode_ff       <= run_mode_in;
         jog_degrees_ff    <= jog_degrees_in;
         direction_bit_ff  <= direction_bit_in;
         lamp_bits_ff      <= lamp_bits_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (!out_valid_ff || rsp_pop) begin
            out_valid_ff <= skid_valid_ff || req_accept;
         end
         if (skid_valid_ff) begin
            if (rsp_pop) begin
               skid_valid_ff <= req_accept;
            end
         end else begin
            skid_valid_ff <= req_accept && out_valid_ff && !rsp_pop;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!out_valid_ff || rsp_pop) begin
         out_ff <= skid_valid_ff ? skid_ff : result;
      end
      if ((skid_valid_ff && rsp_pop) || (!skid_valid_ff && out_valid_ff && !rsp_pop)) begin
         skid_ff <= result;
      end
   end

   `TARC_ASSERT_SAME(a_skid_behind_out, clock, reset, skid_valid_ff, out_valid_ff)
   `TARC_ASSERT_SAME(a_turn_has_degrees, clock, reset,
      run_mode_ff == tarc_pkg::MODE_TURN, degrees_left_ff != 9'd0)
   `TARC_ASSERT_SAME(a_position_range, clock, reset, 1'b1,
      position_ff <= tarc_pkg::MAX_POS && jog_degrees_ff <= tarc_pkg::MAX_POS)
   `TARC_ASSERT_NEXT(a_busy_drops_bytes, clock, reset,
      req_accept && !req_tuser && run_mode_ff != tarc_pkg::MODE_IDLE,
      $stable(frame_index_ff) && $stable(target_accum_ff))

endmodule

`default_nettype wire

FILE: tb/timed_azimuth_rotor_controller_unit_test.sv
// Self-checking stream testbench for the timed azimuth rotor controller unit.
module timed_azimuth_rotor_controller_unit_test;
   import tarc_pkg::*;

   localparam int FRAME_LEN   = 12;
   localparam int CYCLE_LIMIT = 2000000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [8:0]  csr_data = '0;

   timed_azimuth_rotor_controller_unit #(
      .FRAME_BYTES(FRAME_LEN)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #10 clock = ~clock;

   // Predicted controller state and register copies.
   logic [7:0] cfg_ms = RESET_MS_PER_DEGREE;
   logic [8:0] cfg_db = RESET_DEADBAND;
   logic [8:0] rot_pos = '0;
   logic [3:0] rot_frame_idx = '0;
   logic [9:0] rot_accum = '0;
   logic       rot_closed = 1'b0;
   logic       rot_digit_seen = 1'b0;
   logic [8:0] rot_target = '0;
   logic [8:0] rot_deg_left = '0;
   logic [7:0] rot_ms_cnt = '0;
   logic [1:0] rot_mode = MODE_IDLE;
   logic [8:0] rot_jog_deg = '0;
   logic       rot_dir = 1'b0;
   logic [1:0] rot_lamps = '0;

   rsp_word_type rotor_status_q[$];
   int  error_count = 0;
   int  words_sent = 0;
   int  cycle_count = 0;
   bit  steady = 1'b0;
   bit  hold_request = 1'b0;

   function automatic logic [8:0] live_azimuth();
      logic [9:0] sum;
      sum = {1'b0, rot_pos} + {1'b0, rot_jog_deg};
      if (rot_mode == MODE_JOG_CW) begin
         return (sum > {1'b0, MAX_POS}) ? MAX_POS : sum[8:0];
      end
      if (rot_mode == MODE_JOG_CCW) begin
         return (rot_pos >= rot_jog_deg) ? rot_pos - rot_jog_deg : 9'd0;
      end
      return rot_pos;
   endfunction

   function automatic bit degree_tick();
      if (int'(rot_ms_cnt) + 1 >= int'(cfg_ms)) begin
         rot_ms_cnt = '0;
         return 1'b1;
      end
      rot_ms_cnt = rot_ms_cnt + 8'd1;
      return 1'b0;
   endfunction

   function automatic void launch_turn();
      logic [8:0] t;
      logic [8:0] diff;
      t = (rot_accum > MAX_TARGET) ? MAX_TARGET[8:0] : rot_accum[8:0];
      rot_target = t;
      if (t < rot_pos) begin
         rot_lamps = 2'b10;
         rot_dir = 1'b0;
         diff = rot_pos - t;
      end else if (t > rot_pos) begin
         rot_lamps = 2'b01;
         rot_dir = 1'b1;
         diff = t - rot_pos;
      end else begin
         rot_lamps = 2'b00;
         diff = '0;
      end
      if (diff > cfg_db) begin
         rot_mode = MODE_TURN;
         rot_deg_left = diff;
         rot_ms_cnt = '0;
      end
   endfunction

   function automatic void take_rx_byte(logic [7:0] b);
      logic [3:0] p;
      p = rot_frame_idx;
      if (p == 4'd0) begin
         if (b == START_CHAR) begin
            rot_frame_idx = 4'd1;
            rot_accum = '0;
            rot_closed = 1'b0;
            rot_digit_seen = 1'b0;
         end
         return;
      end
      if (p >= FIELD_FIRST && p <= FIELD_LAST && !rot_closed) begin
         if (b >= DIGIT_ZERO && b <= DIGIT_NINE) begin
            rot_accum = rot_accum * 10 + (b - DIGIT_ZERO);
            rot_digit_seen = 1'b1;
         end else if (!(b == SPACE_CHAR && !rot_digit_seen)) begin
            rot_closed = 1'b1;
         end
      end
      if (p >= FRAME_LEN) begin
         rot_frame_idx = 4'd0;
         launch_turn();
      end else begin
         rot_frame_idx = p + 4'd1;
      end
   endfunction

   function automatic void take_tick(logic cw, logic ccw);
      logic held;
      if (rot_mode == MODE_TURN) begin
         if (degree_tick()) begin
            if (rot_deg_left > 0) rot_deg_left = rot_deg_left - 9'd1;
            if (rot_deg_left == 0) begin
               rot_pos = rot_target;
               rot_mode = MODE_IDLE;
            end
         end
         return;
      end
      if (rot_mode == MODE_JOG_CW || rot_mode == MODE_JOG_CCW) begin
         held = (rot_mode == MODE_JOG_CW) ? cw : ccw;
         if (held) begin
            if (degree_tick() && rot_jog_deg < MAX_POS) rot_jog_deg = rot_jog_deg + 9'd1;
            return;
         end
         rot_pos = live_azimuth();
         rot_mode = MODE_IDLE;
      end
      if (ccw) begin
         rot_mode = MODE_JOG_CCW;
         rot_lamps[1] = 1'b1;
         rot_dir = 1'b0;
         rot_ms_cnt = '0;
         rot_jog_deg = '0;
      end else if (cw) begin
         rot_mode = MODE_JOG_CW;
         rot_lamps[0] = 1'b1;
         rot_dir = 1'b1;
         rot_ms_cnt = '0;
         rot_jog_deg = '0;
      end
   endfunction

   function automatic rsp_word_type advance_rotor(logic kind, logic [7:0] rx, logic cw,
                                                  logic ccw);
      rsp_word_type w;
      w = '0;
      if (!kind) begin
         if (rot_mode == MODE_IDLE) take_rx_byte(rx);
      end else begin
         take_tick(cw, ccw);
      end
      w.run_relay = (rot_mode != MODE_IDLE);
      w.dir_relay = rot_dir;
      w.cw_lamp   = rot_lamps[0];
      w.ccw_lamp  = rot_lamps[1];
      w.azimuth   = live_azimuth();
      w.mode      = rot_mode;
      return w;
   endfunction

   task automatic send_word(input logic kind, input logic [7:0] rx, input logic cw,
                            input logic ccw);
      int gap;
      req_word_type w;
      gap = steady ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      w.rx_byte = rx;
      w.cw_button = cw;
      w.ccw_button = ccw;
      req_tdata <= {6'd0, w};
      req_tuser <= kind;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      rotor_status_q.push_back(advance_rotor(kind, rx, cw, ccw));
      words_sent++;
      @(negedge clock);
   endtask

   task automatic send_rx(input logic [7:0] b);
      send_word(1'b0, b, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
   endtask

   task automatic send_tick(input logic cw, input logic ccw);
      send_word(1'b1, 8'($urandom_range(0, 255)), cw, ccw);
   endtask

   task automatic send_frame(input logic [7:0] f2, input logic [7:0] f3,
                             input logic [7:0] f4);
      send_rx(START_CHAR);
      send_rx(8'($urandom_range(0, 255)));
      send_rx(f2);
      send_rx(f3);
      send_rx(f4);
      for (int i = 5; i <= FRAME_LEN; i++) send_rx(8'($urandom_range(0, 255)));
   endtask

   task automatic settle_rotor();
      while (rot_mode != MODE_IDLE) send_tick(1'b0, 1'b0);
   endtask

   task automatic hold_buttons(input logic cw, input logic ccw, input int n);
      repeat (n) send_tick(cw, ccw);
   endtask

   // Registers change only with the controller idle and every result word drained.
   task automatic write_reg(input logic [1:0] idx, input logic [8:0] val);
      settle_rotor();
      req_tvalid <= 1'b0;
      while (rotor_status_q.size() != 0) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      if (idx == REG_MS_PER_DEGREE) cfg_ms = val[7:0];
      else if (idx == REG_DEADBAND) cfg_db = val;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_rate(input logic [8:0] ms, input logic [8:0] db);
      write_reg(REG_MS_PER_DEGREE, ms);
      write_reg(REG_DEADBAND, db);
   endtask

   function automatic logic [7:0] field_char();
      case ($urandom_range(0, 4))
         0: return SPACE_CHAR;
         1: return DIGIT_ZERO + 8'($urandom_range(0, 9));
         2: return "+";
         3: return "-";
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic pick_target_field(output logic [7:0] f2, output logic [7:0] f3,
                                    output logic [7:0] f4);
      int v;
      logic [7:0] d0, d1, d2;
      if ($urandom_range(0, 9) < 6) begin
         v = $urandom_range(0, 24);
         v = v + int'(rot_pos) - 12;
         if (v < 0) v = 0;
         if (v > 359) v = 359;
      end else begin
         v = $urandom_range(0, 999);
      end
      d0 = DIGIT_ZERO + 8'(v / 100);
      d1 = DIGIT_ZERO + 8'((v / 10) % 10);
      d2 = DIGIT_ZERO + 8'(v % 10);
      case ($urandom_range(0, 3))
         0: begin
            f2 = d0; f3 = d1; f4 = d2;
         end
         1: begin
            f2 = (v < 100) ? SPACE_CHAR : d0;
            f3 = (v < 10) ? SPACE_CHAR : d1;
            f4 = d2;
         end
         2: begin
            f2 = d1; f3 = d2; f4 = 8'($urandom_range(0, 255));
         end
         default: begin
            f2 = field_char(); f3 = field_char(); f4 = field_char();
         end
      endcase
   endtask

   task automatic tick_burst();
      int n;
      int pat;
      n = $urandom_range(1, 40);
      pat = $urandom_range(0, 3);
      repeat (n) begin
         if ($urandom_range(0, 9) == 0) pat = $urandom_range(0, 3);
         send_tick(pat[0], pat[1]);
      end
   endtask

   task automatic test_reset_defaults();
      send_frame(SPACE_CHAR, SPACE_CHAR, "3");
      send_frame("0", "0", "0");
   endtask

   task automatic test_target_parsing();
      set_rate(9'd1, 9'd0);
      send_frame(SPACE_CHAR, SPACE_CHAR, "7");
      settle_rotor();
      send_frame("1", "2", SPACE_CHAR);
      settle_rotor();
      send_frame("+", "9", SPACE_CHAR);
      settle_rotor();
      send_frame("9", "9", "9");
      settle_rotor();
      send_frame("4", SPACE_CHAR, "5");
      settle_rotor();
      send_frame("-", "1", "2");
      settle_rotor();
      send_frame("q", "8", "8");
      settle_rotor();
      send_frame(SPACE_CHAR, SPACE_CHAR, SPACE_CHAR);
      settle_rotor();
   endtask

   task automatic test_busy_discard();
      set_rate(9'd2, 9'd0);
      send_rx(START_CHAR);
      send_rx("z");
      send_rx("2");
      send_tick(1'b1, 1'b0);
      send_rx("9");
      send_rx(START_CHAR);
      send_rx("9");
      hold_buttons(1'b1, 1'b0, 6);
      send_tick(1'b0, 1'b0);
      send_rx("0");
      send_rx("x");
      for (int i = 5; i <= FRAME_LEN; i++) send_rx(8'($urandom_range(0, 255)));
      send_frame("5", "5", "5");
      repeat (10) send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      settle_rotor();
   endtask

   task automatic test_jog_priority();
      set_rate(9'd2, 9'd0);
      hold_buttons(1'b1, 1'b1, 5);
      hold_buttons(1'b1, 1'b0, 7);
      hold_buttons(1'b0, 1'b1, 4);
      send_tick(1'b0, 1'b0);
      hold_buttons(1'b1, 1'b0, 3);
      send_tick(1'b0, 1'b0);
   endtask

   task automatic test_jog_saturation();
      set_rate(9'd0, 9'd359);
      hold_buttons(1'b1, 1'b0, 370);
      send_tick(1'b0, 1'b0);
      hold_buttons(1'b0, 1'b1, 370);
      send_tick(1'b0, 1'b0);
      hold_buttons(1'b1, 1'b0, 370);
      send_tick(1'b0, 1'b0);
      send_frame("0", "0", "0");
      settle_rotor();
   endtask

   task automatic test_slow_rate();
      set_rate(9'd255, 9'd0);
      send_frame(SPACE_CHAR, SPACE_CHAR, "1");
      repeat (40) send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      settle_rotor();
      hold_buttons(1'b1, 1'b0, 300);
      send_tick(1'b0, 1'b0);
   endtask

   task automatic test_backpressure();
      set_rate(9'd1, 9'd0);
      hold_request = 1'b1;
      steady = 1'b1;
      repeat (30) begin
         if ($urandom_range(0, 1)) send_rx(8'($urandom_range(0, 255)));
         else send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end
      steady = 1'b0;
      settle_rotor();
   endtask

   task automatic test_random_phases();
      int phase_end;
      logic [7:0] f2, f3, f4;
      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: set_rate(9'd1, 9'd0);
            1: set_rate(9'd0, 9'($urandom_range(0, 10)));
            2: set_rate(9'd2, 9'd5);
            3: set_rate(9'd3, 9'd359);
            4: set_rate(9'd255, 9'd511);
            default: set_rate(9'($urandom_range(0, 3)), 9'($urandom_range(0, 20)));
         endcase
         phase_end = words_sent + 125;
         while (words_sent < phase_end) begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3: begin
                  if ($urandom_range(0, 9) < 7) settle_rotor();
                  pick_target_field(f2, f3, f4);
                  send_frame(f2, f3, f4);
                  if ($urandom_range(0, 9) < 7 && cfg_ms != 8'd255) settle_rotor();
               end
               4, 5, 6: tick_burst();
               7: repeat ($urandom_range(1, 5)) begin
                  if ($urandom_range(0, 7) == 0) send_rx(START_CHAR);
                  else send_rx(8'($urandom_range(0, 255)));
               end
               8: begin
                  send_rx(START_CHAR);
                  repeat ($urandom_range(0, 10)) send_rx(field_char());
               end
               default: steady = ~steady;
            endcase
         end
         steady = 1'b0;
      end
   endtask

   initial begin : result_drain
      int stall;
      stall = 0;
      forever begin
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         @(negedge clock);
         if (hold_request) begin
            stall = 240;
            hold_request = 1'b0;
         end else begin
            stall = steady ? 0 : $urandom_range(0, 18);
         end
      end
   end

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_word_type want;
      rsp_word_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (rotor_status_q.size() == 0) begin
            $display("%0t: result word expected none, got %h", $time, rsp_tdata);
            error_count++;
         end else begin
            want = rotor_status_q.pop_front();
            check_field("run_relay", want.run_relay, got.run_relay);
            check_field("dir_relay", want.dir_relay, got.dir_relay);
            check_field("cw_lamp", want.cw_lamp, got.cw_lamp);
            check_field("ccw_lamp", want.ccw_lamp, got.ccw_lamp);
            check_field("azimuth", want.azimuth, got.azimuth);
            check_field("mode", want.mode, got.mode);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timed_azimuth_rotor_controller_unit_test: done, errors");
         $finish;
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_target_parsing();
      test_busy_discard();
      test_jog_priority();
      test_jog_saturation();
      test_slow_rate();
      test_backpressure();
      test_random_phases();
      req_tvalid <= 1'b0;
      while (rotor_status_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (error_count == 0) begin
         $display("timed_azimuth_rotor_controller_unit_test: done, clean");
      end else begin
         $display("timed_azimuth_rotor_controller_unit_test: done, errors");
      end
      $finish;
   end

endmodule
